### rtl/orot_pkg.sv
// shared types and widths for the oriented rectangle overlap test
package orot_pkg;

    localparam int IN_W   = 16;
    localparam int PROD_W = 2 * IN_W;
    localparam int ABS_W  = PROD_W;
    localparam int SUM_W  = ABS_W + 2;
    localparam int CTR2_W = ABS_W + 1;
    localparam int N_EDGE = 4;
    localparam int LAT    = 4;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
    } t_vec;

endpackage

### rtl/orot_dot.sv
// one dot product lane: registered products, then registered magnitude of their sum
module orot_dot (
    input  logic                          i_clk,
    input  orot_pkg::t_vec                i_a,
    input  orot_pkg::t_vec                i_b,
    output logic [orot_pkg::ABS_W-1:0]    o_abs
);

    logic signed [orot_pkg::PROD_W-1:0] r_px;
    logic signed [orot_pkg::PROD_W-1:0] r_py;
    logic signed [orot_pkg::PROD_W-1:0] n_px;
    logic signed [orot_pkg::PROD_W-1:0] n_py;
    logic signed [orot_pkg::PROD_W:0]   w_dot;
    logic        [orot_pkg::PROD_W:0]   w_mag;
    logic        [orot_pkg::ABS_W-1:0]  r_abs;

    assign n_px = i_a.x * i_b.x;
    assign n_py = i_a.y * i_b.y;

    assign w_dot = {r_px[orot_pkg::PROD_W-1], r_px} + {r_py[orot_pkg::PROD_W-1], r_py};
    // magnitude never exceeds 2^31, so it fits the unsigned result
    assign w_mag = w_dot[orot_pkg::PROD_W] ? (~w_dot + 1'b1) : w_dot;

    always_ff @(posedge i_clk) begin
        r_px  <= n_px;
        r_py  <= n_py;
        r_abs <= w_mag[orot_pkg::ABS_W-1:0];
    end

    assign o_abs = r_abs;

endmodule

### rtl/orot_axis.sv
// one test axis: registered projection sum and doubled centre term, then the separation compare
module orot_axis (
    input  logic                          i_clk,
    input  logic [orot_pkg::ABS_W-1:0]    i_edge_abs [orot_pkg::N_EDGE],
    input  logic [orot_pkg::ABS_W-1:0]    i_ctr_abs,
    output logic                          o_sep
);

    logic [orot_pkg::SUM_W-1:0]  n_sum;
    logic [orot_pkg::SUM_W-1:0]  r_sum;
    logic [orot_pkg::CTR2_W-1:0] r_ctr2;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < orot_pkg::N_EDGE; k++) begin
            n_sum = n_sum + {{(orot_pkg::SUM_W - orot_pkg::ABS_W){1'b0}}, i_edge_abs[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_ctr2 <= {i_ctr_abs, 1'b0};
    end

    // zero-length axis gives 0 < 0, never separating
    assign o_sep = r_sum < {{(orot_pkg::SUM_W - orot_pkg::CTR2_W){1'b0}}, r_ctr2};

endmodule

### rtl/oriented_rect_overlap_test.sv
// top level of the 2-d oriented rectangle overlap test
//
// usage: present the edge vectors, four of them, and the centre difference on
// the input ports and raise start for one cycle; the item is taken at the rising
// edge where start is high and busy is low. busy is always low, so a new item may
// be started in every cycle.
// the result appears on o_overlap together with o_strobe for exactly one
// cycle, once the item has passed the pipeline registers listed below. one
// item per cycle sustained, results in the order items went in.
// pipeline: products in the multiplier stage (28 16x16 multipliers), dot
// product magnitudes, per-axis sums and doubled centre projection, then the
// compare of all four axes into the output register.
// reset clears the valid bits, so items in flight are dropped and no strobe
// follows. the receiver has no way to stall, so results are never held back.
module oriented_rect_overlap_test (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [orot_pkg::IN_W-1:0]   i_left_edge_a_x,
    input  logic signed [orot_pkg::IN_W-1:0]   i_left_edge_a_y,
    input  logic signed [orot_pkg::IN_W-1:0]   i_left_edge_b_x,
    input  logic signed [orot_pkg::IN_W-1:0]   i_left_edge_b_y,
    input  logic signed [orot_pkg::IN_W-1:0]   i_right_edge_a_x,
    input  logic signed [orot_pkg::IN_W-1:0]   i_right_edge_a_y,
    input  logic signed [orot_pkg::IN_W-1:0]   i_right_edge_b_x,
    input  logic signed [orot_pkg::IN_W-1:0]   i_right_edge_b_y,
    input  logic signed [orot_pkg::IN_W-1:0]   i_center_dx,
    input  logic signed [orot_pkg::IN_W-1:0]   i_center_dy,
    output logic                               o_overlap,
    output logic                               o_strobe
);

    orot_pkg::t_vec w_edge [orot_pkg::N_EDGE];
    orot_pkg::t_vec w_ctr;

    logic [orot_pkg::ABS_W-1:0] w_ee  [orot_pkg::N_EDGE][orot_pkg::N_EDGE];
    logic [orot_pkg::ABS_W-1:0] w_ce  [orot_pkg::N_EDGE];
    logic [orot_pkg::N_EDGE-1:0] w_sep;

    logic       w_accept;
    logic [2:0] r_vld;
    logic       r_strobe;
    logic       r_overlap;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    assign w_edge[0] = '{x: i_left_edge_a_x,  y: i_left_edge_a_y};
    assign w_edge[1] = '{x: i_left_edge_b_x,  y: i_left_edge_b_y};
    assign w_edge[2] = '{x: i_right_edge_a_x, y: i_right_edge_a_y};
    assign w_edge[3] = '{x: i_right_edge_b_x, y: i_right_edge_b_y};
    assign w_ctr     = '{x: i_center_dx,      y: i_center_dy};

    // edge-edge dots are symmetric: one lane per unordered pair
    for (genvar i = 0; i < orot_pkg::N_EDGE; i++) begin : g_axis
        for (genvar k = 0; k < orot_pkg::N_EDGE; k++) begin : g_edge
            if (k <= i) begin : g_lane
                orot_dot u_dot (
                    .i_clk (i_clk),
                    .i_a   (w_edge[k]),
                    .i_b   (w_edge[i]),
                    .o_abs (w_ee[i][k])
                );
            end else begin : g_mirror
                assign w_ee[i][k] = w_ee[k][i];
            end
        end

        orot_dot u_ctr_dot (
            .i_clk (i_clk),
            .i_a   (w_ctr),
            .i_b   (w_edge[i]),
            .o_abs (w_ce[i])
        );

        orot_axis u_axis (
            .i_clk      (i_clk),
            .i_edge_abs (w_ee[i]),
            .i_ctr_abs  (w_ce[i]),
            .o_sep      (w_sep[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[1:0], w_accept};
            r_strobe <= r_vld[2];
        end
        r_overlap <= ~|w_sep;
    end

    assign o_overlap = r_overlap;
    assign o_strobe  = r_strobe;

`ifndef SYNTHESIS
    logic w_edges_zero;
    assign w_edges_zero = (w_edge[0] == '0) && (w_edge[1] == '0)
                       && (w_edge[2] == '0) && (w_edge[3] == '0);

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(orot_pkg::LAT) o_strobe)
        else $error("accepted item produced no result");

    a_no_stray_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, orot_pkg::LAT))
        else $error("result without a matching item");

    a_zero_edges_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(w_edges_zero, orot_pkg::LAT)) |-> o_overlap)
        else $error("all-zero edges must report overlap");
`endif

endmodule

### sim/testbench.sv
// testbench for the oriented rectangle overlap test: self-checking, directed and random items
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [orot_pkg::IN_W-1:0] t_coord;

    // edges[0..1] belong to the left rectangle, edges[2..3] to the right one
    typedef struct packed {
        orot_pkg::t_vec [0:orot_pkg::N_EDGE-1] edges;
        orot_pkg::t_vec                        ctr;
    } t_pair_item;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord i_left_edge_a_x;
    t_coord i_left_edge_a_y;
    t_coord i_left_edge_b_x;
    t_coord i_left_edge_b_y;
    t_coord i_right_edge_a_x;
    t_coord i_right_edge_a_y;
    t_coord i_right_edge_b_x;
    t_coord i_right_edge_b_y;
    t_coord i_center_dx;
    t_coord i_center_dy;
    logic   o_overlap;
    logic   o_strobe;

    logic overlap_expected_q[$];
    logic overlap_exp;
    int   n_errors;
    int   n_directed;
    int   n_random;
    int   n_checked;
    int   n_overlap_pred;
    int   n_separated_pred;
    int   cycle_count;
    int   sender_idle_pct;

    oriented_rect_overlap_test u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_left_edge_a_x  (i_left_edge_a_x),
        .i_left_edge_a_y  (i_left_edge_a_y),
        .i_left_edge_b_x  (i_left_edge_b_x),
        .i_left_edge_b_y  (i_left_edge_b_y),
        .i_right_edge_a_x (i_right_edge_a_x),
        .i_right_edge_a_y (i_right_edge_a_y),
        .i_right_edge_b_x (i_right_edge_b_x),
        .i_right_edge_b_y (i_right_edge_b_y),
        .i_center_dx      (i_center_dx),
        .i_center_dy      (i_center_dy),
        .o_overlap        (o_overlap),
        .o_strobe         (o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint dot_vec(orot_pkg::t_vec a, orot_pkg::t_vec b);
        return longint'($signed(a.x)) * longint'($signed(b.x))
             + longint'($signed(a.y)) * longint'($signed(b.y));
    endfunction

    // separating axis test with each edge vector as an axis (four in all), exact wide arithmetic
    function automatic logic predict_overlap(t_pair_item it);
        longint sum_proj;
        longint ctr_proj;
        longint d;
        logic   separated;
        separated = 1'b0;
        for (int ax = 0; ax < orot_pkg::N_EDGE; ax++) begin
            sum_proj = 0;
            for (int k = 0; k < orot_pkg::N_EDGE; k++) begin
                d = dot_vec(it.edges[k], it.edges[ax]);
                sum_proj += (d < 0) ? -d : d;
            end
            d = dot_vec(it.ctr, it.edges[ax]);
            ctr_proj = (d < 0) ? -d : d;
            // zero-length axis gives 0 < 0, never separating
            if (sum_proj < 2 * ctr_proj)
                separated = 1'b1;
        end
        return !separated;
    endfunction

    function automatic t_pair_item make_item(int lax, int lay, int lbx, int lby,
                                             int rax, int ray, int rbx, int rby,
                                             int cx, int cy);
        t_pair_item it;
        it.edges[0] = '{x: t_coord'(lax), y: t_coord'(lay)};
        it.edges[1] = '{x: t_coord'(lbx), y: t_coord'(lby)};
        it.edges[2] = '{x: t_coord'(rax), y: t_coord'(ray)};
        it.edges[3] = '{x: t_coord'(rbx), y: t_coord'(rby)};
        it.ctr      = '{x: t_coord'(cx), y: t_coord'(cy)};
        return it;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return t_coord'(int'($urandom_range(0, 128)) - 64);
            default: return t_coord'($urandom());
        endcase
    endfunction

    // rectangles with nearly perpendicular edges, centre near the contact distance
    function automatic t_pair_item rand_rect_pair();
        t_pair_item it;
        int r;
        int ax;
        int ay;
        int s;
        r = 1 << $urandom_range(2, 11);
        for (int j = 0; j < 2; j++) begin
            ax = int'($urandom_range(0, 2 * r)) - r;
            ay = int'($urandom_range(0, 2 * r)) - r;
            s  = $urandom_range(1, 8);
            it.edges[2*j]   = '{x: t_coord'(ax), y: t_coord'(ay)};
            it.edges[2*j+1] = '{x: t_coord'(-(ay * s) / 4), y: t_coord'((ax * s) / 4)};
        end
        it.ctr.x = t_coord'(int'($urandom_range(0, 6 * r)) - 3 * r);
        it.ctr.y = t_coord'(int'($urandom_range(0, 6 * r)) - 3 * r);
        return it;
    endfunction

    function automatic t_pair_item rand_pair_item();
        t_pair_item it;
        if ($urandom_range(0, 99) < 70)
            return rand_rect_pair();
        for (int k = 0; k < orot_pkg::N_EDGE; k++)
            it.edges[k] = '{x: rand_coord(), y: rand_coord()};
        it.ctr = '{x: rand_coord(), y: rand_coord()};
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        n_errors++;
    endtask

    // drive one item and hold it until the block takes it
    task automatic send_item(t_pair_item it);
        if (sender_idle_pct > 0) begin
            while ($urandom_range(0, 99) < sender_idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start            <= 1'b1;
        i_left_edge_a_x  <= it.edges[0].x;
        i_left_edge_a_y  <= it.edges[0].y;
        i_left_edge_b_x  <= it.edges[1].x;
        i_left_edge_b_y  <= it.edges[1].y;
        i_right_edge_a_x <= it.edges[2].x;
        i_right_edge_a_y <= it.edges[2].y;
        i_right_edge_b_x <= it.edges[3].x;
        i_right_edge_b_y <= it.edges[3].y;
        i_center_dx      <= it.ctr.x;
        i_center_dy      <= it.ctr.y;
        do @(posedge i_clk); while (busy !== 1'b0);
        overlap_expected_q.push_back(predict_overlap(it));
        if (predict_overlap(it))
            n_overlap_pred++;
        else
            n_separated_pred++;
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (overlap_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        t_pair_item items[$];
        sender_idle_pct = 0;
        items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        items.push_back(make_item(16, 0, 0, 16, 16, 0, 0, 16, 0, 0));
        items.push_back(make_item(16, 0, 0, 16, 16, 0, 0, 16, 64, 0));
        // exactly touching along x: sum equals twice the centre projection
        items.push_back(make_item(16, 0, 0, 16, 16, 0, 0, 16, 16, 0));
        items.push_back(make_item(16, 0, 0, 16, 16, 0, 0, 16, 17, 0));
        items.push_back(make_item(16, 0, 0, 16, 16, 0, 0, 16, 0, -17));
        // zero-length axes on one or both rectangles
        items.push_back(make_item(0, 0, 0, 0, 16, 0, 0, 16, 5000, 5000));
        items.push_back(make_item(0, 0, 0, 16, 16, 0, 0, 0, 0, 9000));
        items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, -32768, 32767));
        items.push_back(make_item(32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767));
        items.push_back(make_item(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768));
        items.push_back(make_item(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, 32767, 32767));
        items.push_back(make_item(32767, -32768, -32768, 32767, 32767, -32768,
                                  -32768, 32767, -32768, 32767));
        items.push_back(make_item(-32768, 0, 0, 1, 1, 0, 0, -32768, 32767, -32768));
        // parallel edges, degenerate shape
        items.push_back(make_item(16, 16, 32, 32, 0, 16, 16, 0, 100, -100));
        // diamond against a square
        items.push_back(make_item(16, 16, -16, 16, 16, 0, 0, 16, 40, 0));
        items.push_back(make_item(16, 16, -16, 16, 16, 0, 0, 16, 24, 24));
        // skewed, non-rectangular
        items.push_back(make_item(48, 8, 5, -30, -20, 7, 3, 60, -70, 41));
        items.push_back(make_item(21845, -21846, -21846, 21845, 21845, 21845,
                                  -21846, -21846, 21845, -21846));
        items.push_back(make_item(-1, -1, 1, -1, 1, 1, -1, 1, 0, 0));
        items.push_back(make_item(32767, 0, 0, 32767, -32768, 0, 0, -32768, 32767, 0));
        foreach (items[i]) begin
            send_item(items[i]);
            n_directed++;
        end
    endtask

    task automatic test_random_stream(int n_items, int idle_pct);
        for (int i = 0; i < n_items; i++) begin
            // now and then a stretch with no idling at all
            if (i % 32 == 0)
                sender_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
            send_item(rand_pair_item());
            n_random++;
        end
    endtask

    // let the pipeline drain completely in the middle of a stream
    task automatic test_drain_pause();
        sender_idle_pct = 0;
        for (int i = 0; i < 20; i++) begin
            if (i == 10)
                wait_all_results();
            send_item(rand_pair_item());
            n_random++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                report_mismatch("strobe unknown");
            end else if (o_strobe) begin
                if (overlap_expected_q.size() == 0) begin
                    report_mismatch("result with no item waiting");
                end else begin
                    overlap_exp = overlap_expected_q.pop_front();
                    n_checked++;
                    if (o_overlap !== overlap_exp)
                        report_mismatch($sformatf("overlap got %b expected %b",
                                                  o_overlap, overlap_exp));
                end
            end
        end
    end

    initial begin
        n_errors         = 0;
        n_directed       = 0;
        n_random         = 0;
        n_checked        = 0;
        n_overlap_pred   = 0;
        n_separated_pred = 0;
        cycle_count      = 0;
        sender_idle_pct  = 0;
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_left_edge_a_x  <= '0;
        i_left_edge_a_y  <= '0;
        i_left_edge_b_x  <= '0;
        i_left_edge_b_y  <= '0;
        i_right_edge_a_x <= '0;
        i_right_edge_a_y <= '0;
        i_right_edge_b_x <= '0;
        i_right_edge_b_y <= '0;
        i_center_dx      <= '0;
        i_center_dy      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_stream(480, 0);
        test_drain_pause();
        test_random_stream(480, 64);
        test_random_stream(480, 22);
        test_random_stream(480, 0);

        wait_all_results();
        repeat (orot_pkg::LAT + 4) @(posedge i_clk);
        $display("ran %0d directed and %0d random items, %0d results checked",
                 n_directed, n_random, n_checked);
        $display("pairs predicted overlapping: %0d, separated: %0d",
                 n_overlap_pred, n_separated_pred);
        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("testbench failed");
        end
        $finish;
    end

endmodule
